// ===== rtl/cigar_alignment_log_scorer_unit_defines.svh =====
// Assertion macros shared by the checker of the alignment log scorer
`ifndef CIGAR_ALIGNMENT_LOG_SCORER_UNIT_DEFINES_SVH
`define CIGAR_ALIGNMENT_LOG_SCORER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CALS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cals check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CALS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cals check failed");

`endif

// ===== rtl/cals_pkg.sv =====
// Types, codes and constant tables of the alignment log scorer
package cals_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int MAX_QUALITY_DEF = 93;

  localparam int GAP_W   = 21;
  localparam int SCORE_W = 32;
  localparam int TERM_W  = SCORE_W + 1;
  localparam int QUAL_W  = 7;
  localparam int BASE_W  = 8;
  localparam int OP_W    = 3;
  localparam int TAB_N   = 1 << QUAL_W;

  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = OP_W + 1;
  localparam int M_TDATA_W = SCORE_W;
  localparam int M_TUSER_W = 1;

  localparam logic signed [GAP_W-1:0] GAP_RESET = -21'sd65536;

  localparam logic [63:0] Q32_ONE          = 64'h1_0000_0000;
  localparam logic [63:0] TENTH_ROOT40_Q32 = 64'd4054710589;
  localparam logic [63:0] LOG10_2_Q32      = 64'd1292913986;

  // Configuration register indexes
  typedef enum logic {
    REG_GAP_OPEN   = 1'b0,
    REG_GAP_EXTEND = 1'b1
  } reg_idx_e;

  // CIGAR operation codes
  typedef enum logic [OP_W-1:0] {
    OP_MATCH  = 3'd0,
    OP_INS    = 3'd1,
    OP_DEL    = 3'd2,
    OP_SCLIP  = 3'd3,
    OP_UNSUPP = 3'd4
  } op_e;

  typedef logic signed [SCORE_W-1:0] tab_t [TAB_N];

  // Term handed from the term logic to the accumulator
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     bad;
  } term_t;

  // -log10(y / 2^32) scaled by 2^frac, for 0 < y < 2^32
  function automatic logic [63:0] neg_log10_q32(logic [63:0] y, int frac);
    logic [63:0] m;
    logic [63:0] f;
    logic [63:0] a;
    logic [63:0] r;
    int          ipn;
    m   = y;
    f   = '0;
    ipn = 2;
    for (int k = 0; k < 32; k++) begin
      if (m < (64'd1 << 30)) begin
        m   = m << 1;
        ipn = ipn + 1;
      end
    end
    for (int k = 0; k < 32; k++) begin
      if (m >= (64'd1 << 31)) begin
        m   = m >> 1;
        ipn = ipn - 1;
      end
    end
    for (int i = 1; i <= 32; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f = f | (64'd1 << (32 - i));
      end
    end
    a = (64'(ipn) << 32) - f;
    r = (a >> 32) * LOG10_2_Q32 + (((a & 64'hFFFF_FFFF) * LOG10_2_Q32) >> 32);
    return (r + (64'd1 << (31 - frac))) >> (32 - frac);
  endfunction

  // Match term log10(1 - 10^(-q/40)) for every quality
  function automatic tab_t build_match_tab(int frac);
    tab_t        t;
    logic [63:0] x;
    logic [63:0] mag;
    x    = Q32_ONE;
    t[0] = 32'sh8000_0000;
    for (int q = 1; q < TAB_N; q++) begin
      x = (x * TENTH_ROOT40_Q32 + (64'd1 << 31)) >> 32;
      if (x == 0) begin
        t[q] = '0;
      end else if (x >= Q32_ONE) begin
        t[q] = 32'sh8000_0000;
      end else begin
        mag = neg_log10_q32(Q32_ONE - x, frac);
        if (mag > 64'd2147483647) begin
          t[q] = 32'sh8000_0000;
        end else begin
          t[q] = -$signed(mag[SCORE_W-1:0]);
        end
      end
    end
    return t;
  endfunction

  // Quality penalty q/40, rounded half up, for every quality
  function automatic tab_t build_qpen_tab(int frac);
    tab_t        t;
    logic [63:0] v;
    for (int q = 0; q < TAB_N; q++) begin
      v    = ((64'(q) << frac) + 64'd20) / 64'd40;
      t[q] = $signed(v[SCORE_W-1:0]);
    end
    return t;
  endfunction

endpackage

// ===== rtl/cigar_alignment_log_scorer_unit.sv =====
// Top level of the CIGAR alignment log-likelihood scorer
//
// Takes one aligned position per cycle and sums log10 P(data | alignment) in signed
// fixed point with FRAC_BITS fraction bits, saturating at 32 bits. An item passes an
// input register, then a combinational table lookup and a single saturating add into
// the accumulator; the item marked tlast loads the score and the unsupported-operation
// flag into the output register and clears both. Throughput is one item per cycle
// while input ready is high; the result of an accepted last item passes the input
// register, then the output register. Input ready drops only while a result waits in
// the output register and a further last item is held behind it. The user must write
// the gap registers only while no item is in flight; the block does not enforce it.
module cigar_alignment_log_scorer_unit #(
  parameter int FRAC_BITS   = cals_pkg::FRAC_BITS_DEF,
  parameter int MAX_QUALITY = cals_pkg::MAX_QUALITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_wr_en_i,
  input  logic                              cfg_addr_i,
  input  logic [cals_pkg::GAP_W-1:0]        cfg_wdata_i,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // read_base [7:0], ref_base [15:8], base_quality [22:16], zero [23]
  input  logic [cals_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // op_code [2:0], entry_start [3]
  input  logic [cals_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  input  logic                              s_axis_tlast,
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // log_score [31:0]
  output logic [cals_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // bad_op [0]
  output logic [cals_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
  import cals_pkg::*;

  localparam logic signed [TERM_W:0] SAT_MAX = (TERM_W+1)'(33'sh0_7FFF_FFFF);
  localparam logic signed [TERM_W:0] SAT_MIN = -(TERM_W+1)'(34'sh0_8000_0000);

  logic signed [GAP_W-1:0]   gap_open_q, gap_extend_q;
  logic                      s1_valid_q;
  logic [OP_W-1:0]           s1_op_q;
  logic [BASE_W-1:0]         s1_rb_q, s1_fb_q;
  logic [QUAL_W-1:0]         s1_qual_q;
  logic                      s1_start_q, s1_last_q;
  logic signed [SCORE_W-1:0] acc_q, acc_d;
  logic                      sticky_q;
  logic                      out_valid_q;
  logic [SCORE_W-1:0]        out_score_q;
  logic                      out_bad_q;
  term_t                     term;
  logic signed [TERM_W:0]    sum;
  logic                      advance;
  logic                      s_req;

  // Write gap penalty registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_q   <= GAP_RESET;
      gap_extend_q <= GAP_RESET;
    end else if (cfg_wr_en_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_GAP_OPEN:   gap_open_q   <= $signed(cfg_wdata_i);
        REG_GAP_EXTEND: gap_extend_q <= $signed(cfg_wdata_i);
        default:        ;
      endcase
    end
  end

  // Stage 1 advances unless a last item would overwrite a waiting result
  assign advance       = !s1_valid_q || !s1_last_q || !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign s_req         = s_axis_tvalid && s_axis_tready;

  // Capture the input request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= s_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_req) begin
      s1_rb_q    <= s_axis_tdata[7:0];
      s1_fb_q    <= s_axis_tdata[15:8];
      s1_qual_q  <= s_axis_tdata[22:16];
      s1_op_q    <= s_axis_tuser[OP_W-1:0];
      s1_start_q <= s_axis_tuser[OP_W];
      s1_last_q  <= s_axis_tlast;
    end
  end

  cals_term #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_QUALITY (MAX_QUALITY)
  ) u_term (
    .op_code_i      (s1_op_q),
    .read_base_i    (s1_rb_q),
    .ref_base_i     (s1_fb_q),
    .base_quality_i (s1_qual_q),
    .entry_start_i  (s1_start_q),
    .gap_open_i     (gap_open_q),
    .gap_extend_i   (gap_extend_q),
    .term_o         (term)
  );

  // Add the term and saturate to 32 bits
  always_comb begin
    sum = (TERM_W+1)'(acc_q) + (TERM_W+1)'(term.term);
    if (sum > SAT_MAX) begin
      acc_d = SCORE_W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      acc_d = SCORE_W'(SAT_MIN);
    end else begin
      acc_d = sum[SCORE_W-1:0];
    end
  end

  // Accumulate, and on the last item load the result and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_valid_q && advance) begin
        if (s1_last_q) begin
          acc_q       <= '0;
          sticky_q    <= 1'b0;
          out_valid_q <= 1'b1;
        end else begin
          acc_q    <= acc_d;
          sticky_q <= sticky_q | term.bad;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && advance && s1_last_q) begin
      out_score_q <= acc_d;
      out_bad_q   <= sticky_q | term.bad;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_score_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

// ===== rtl/cals_term.sv =====
// Per-item log term: quality clamp, table lookups and gap selection
module cals_term #(
  parameter int FRAC_BITS   = cals_pkg::FRAC_BITS_DEF,
  parameter int MAX_QUALITY = cals_pkg::MAX_QUALITY_DEF
) (
  input  logic [cals_pkg::OP_W-1:0]          op_code_i,
  input  logic [cals_pkg::BASE_W-1:0]        read_base_i,
  input  logic [cals_pkg::BASE_W-1:0]        ref_base_i,
  input  logic [cals_pkg::QUAL_W-1:0]        base_quality_i,
  input  logic                               entry_start_i,
  input  logic signed [cals_pkg::GAP_W-1:0]  gap_open_i,
  input  logic signed [cals_pkg::GAP_W-1:0]  gap_extend_i,
  output cals_pkg::term_t                    term_o
);
  import cals_pkg::*;

  localparam tab_t MATCH_TAB = build_match_tab(FRAC_BITS);
  localparam tab_t QPEN_TAB  = build_qpen_tab(FRAC_BITS);
  localparam logic [QUAL_W-1:0] QMAX = QUAL_W'(MAX_QUALITY);

  logic [QUAL_W-1:0]        qual;
  logic signed [TERM_W-1:0] match_val;
  logic signed [TERM_W-1:0] qpen;
  logic signed [TERM_W-1:0] gap;

  // Clamp quality, read both tables and select the gap term
  always_comb begin
    qual      = (base_quality_i > QMAX) ? QMAX : base_quality_i;
    match_val = TERM_W'(MATCH_TAB[qual]);
    qpen      = TERM_W'(QPEN_TAB[qual]);
    gap       = entry_start_i ? TERM_W'(gap_open_i) : TERM_W'(gap_extend_i);
  end

  // Pick the term by operation
  always_comb begin
    term_o.term = '0;
    term_o.bad  = 1'b0;
    case (op_code_i)
      OP_MATCH: term_o.term = (read_base_i == ref_base_i) ? match_val : -qpen;
      OP_INS:   term_o.term = gap - qpen;
      OP_DEL:   term_o.term = gap;
      OP_SCLIP: term_o.term = -qpen;
      default:  term_o.bad  = 1'b1;
    endcase
  end

endmodule

// ===== rtl/cals_checker.sv =====
// Port-level checks of the alignment log scorer, bound to its top level
`include "cigar_alignment_log_scorer_unit_defines.svh"

module cals_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [cals_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [cals_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input logic [cals_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
  import cals_pkg::*;

  logic s_req;
  logic last_req;
  logic bad_last_req;

  assign s_req        = s_axis_tvalid && s_axis_tready;
  assign last_req     = s_req && s_axis_tlast;
  assign bad_last_req = last_req && (s_axis_tuser[OP_W-1:0] >= OP_UNSUPP);

  // Hold a stalled result
  `CALS_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Accept input whenever no result is waiting
  `CALS_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // A fresh result follows a last request
  `CALS_ASSERT_NOW(a_result_source, clk_i, rst_ni, $rose(m_axis_tvalid),
                   $past(last_req, 2))

  // An unsupported operation on the last request flags the result
  `CALS_ASSERT_NOW(a_bad_flag, clk_i, rst_ni, $rose(m_axis_tvalid) && $past(bad_last_req, 2),
                   m_axis_tuser[0])

endmodule

bind cigar_alignment_log_scorer_unit cals_checker u_cals_checker (.*);
